>>> design/hsl_pkg.sv
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types and constants of the HSL to RGB colour converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int unsigned SEXT_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ARGB_W = 32;

  localparam logic [BYTE_W-1:0] ALPHA = 8'hff;

  typedef enum logic [SEXT_W-1:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_e;

endpackage

>>> design/hsl_vm.sv
// ----------------------------------------------------------------------------
// hsl_vm
// First two stages: clamp the inputs, form l*s and the hue sextant, then the
// largest channel v, the smallest channel m and their span d.
// ----------------------------------------------------------------------------
module hsl_vm #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [FRAC_BITS-1:0]  hue_i,
  input  logic [FRAC_BITS:0]    saturation_i,
  input  logic [FRAC_BITS:0]    lightness_i,
  output logic [FRAC_BITS:0]    v_o,
  output logic [FRAC_BITS:0]    m_o,
  output logic [FRAC_BITS:0]    d_o,
  output logic [FRAC_BITS-1:0]  frac_o,
  output hsl_pkg::sextant_e     sext_o
);

  localparam int unsigned UW  = FRAC_BITS + 1;
  localparam int unsigned PW  = 2 * FRAC_BITS + 2;
  localparam int unsigned V2W = 2 * FRAC_BITS + 3;
  localparam int unsigned HW  = FRAC_BITS + hsl_pkg::SEXT_W;
  localparam logic [UW-1:0] ONE  = UW'(1) << FRAC_BITS;
  localparam logic [UW-1:0] HALF = UW'(1) << (FRAC_BITS - 1);

  logic [UW-1:0]        sat_c, light_c;
  logic [HW-1:0]        hue6;
  logic [UW-1:0]        l_q, s_q;
  logic [PW-1:0]        p_q;
  logic [FRAC_BITS-1:0] frac1_q;
  hsl_pkg::sextant_e    sext1_q;

  logic [V2W-1:0]       v2;
  logic [UW-1:0]        v_c;
  logic [UW:0]          m_wide;
  logic [UW-1:0]        m_c;
  logic [UW-1:0]        v_q, m_q, d_q;
  logic [FRAC_BITS-1:0] frac2_q;
  hsl_pkg::sextant_e    sext2_q;

  assign sat_c   = (saturation_i > ONE) ? ONE : saturation_i;
  assign light_c = (lightness_i > ONE) ? ONE : lightness_i;
  assign hue6    = (HW'(hue_i) << 2) + (HW'(hue_i) << 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_q     <= light_c;
      s_q     <= sat_c;
      p_q     <= PW'(light_c) * PW'(sat_c);
      frac1_q <= hue6[FRAC_BITS-1:0];
      sext1_q <= hsl_pkg::sextant_e'(hue6[HW-1:FRAC_BITS]);
    end
  end

  always_comb begin
    if (l_q <= HALF) begin
      v2 = (V2W'(l_q) << FRAC_BITS) + V2W'(p_q);
    end else begin
      v2 = ((V2W'(l_q) + V2W'(s_q)) << FRAC_BITS) - V2W'(p_q);
    end
  end

  assign v_c    = v2[2*FRAC_BITS:FRAC_BITS];
  assign m_wide = {l_q, 1'b0} - {1'b0, v_c};
  assign m_c    = m_wide[UW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q     <= v_c;
      m_q     <= m_c;
      d_q     <= v_c - m_c;
      frac2_q <= frac1_q;
      sext2_q <= sext1_q;
    end
  end

  assign v_o    = v_q;
  assign m_o    = m_q;
  assign d_o    = d_q;
  assign frac_o = frac2_q;
  assign sext_o = sext2_q;

endmodule

>>> design/hsl_chan.sv
// ----------------------------------------------------------------------------
// hsl_chan
// Last two stages: scale the span by the hue fraction, then pick the three
// channels by sextant and turn each into a byte.
// ----------------------------------------------------------------------------
module hsl_chan #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [FRAC_BITS:0]           v_i,
  input  logic [FRAC_BITS:0]           m_i,
  input  logic [FRAC_BITS:0]           d_i,
  input  logic [FRAC_BITS-1:0]         frac_i,
  input  hsl_pkg::sextant_e            sext_i,
  output logic [hsl_pkg::ARGB_W-1:0]   argb_o
);

  localparam int unsigned UW = FRAC_BITS + 1;
  localparam int unsigned MW = 2 * FRAC_BITS + 1;
  localparam int unsigned BW = FRAC_BITS + hsl_pkg::BYTE_W + 1;

  logic [MW-1:0]     prod;
  logic [UW-1:0]     v_q, m_q, vsf_q;
  hsl_pkg::sextant_e sext_q;
  logic [UW-1:0]     mid1, mid2;
  logic [UW-1:0]     r_c, g_c, b_c;
  logic [hsl_pkg::BYTE_W-1:0] r_b, g_b, b_b;
  logic [hsl_pkg::ARGB_W-1:0] argb_q;

  function automatic logic [hsl_pkg::BYTE_W-1:0] to_byte(input logic [UW-1:0] c);
    logic [BW-1:0] x;
    x = (BW'(c) << hsl_pkg::BYTE_W) - BW'(c);
    return x[FRAC_BITS+hsl_pkg::BYTE_W-1:FRAC_BITS];
  endfunction

  assign prod = MW'(d_i) * MW'(frac_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q    <= v_i;
      m_q    <= m_i;
      vsf_q  <= prod[MW-1:FRAC_BITS];
      sext_q <= sext_i;
    end
  end

  assign mid1 = m_q + vsf_q;
  assign mid2 = v_q - vsf_q;

  always_comb begin
    unique case (sext_q)
      hsl_pkg::SEXT_RED_YEL: begin r_c = v_q;  g_c = mid1; b_c = m_q;  end
      hsl_pkg::SEXT_YEL_GRN: begin r_c = mid2; g_c = v_q;  b_c = m_q;  end
      hsl_pkg::SEXT_GRN_CYN: begin r_c = m_q;  g_c = v_q;  b_c = mid1; end
      hsl_pkg::SEXT_CYN_BLU: begin r_c = m_q;  g_c = mid2; b_c = v_q;  end
      hsl_pkg::SEXT_BLU_MAG: begin r_c = mid1; g_c = m_q;  b_c = v_q;  end
      default:               begin r_c = v_q;  g_c = m_q;  b_c = mid2; end
    endcase
  end

  assign r_b = to_byte(r_c);
  assign g_b = to_byte(g_c);
  assign b_b = to_byte(b_c);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      argb_q <= {hsl_pkg::ALPHA, r_b, g_b, b_b};
    end
  end

  assign argb_o = argb_q;

endmodule

>>> design/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL pixel to packed ARGB colour, four-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while stall_o is low and returns its colour
// once it has passed every stage. The pipeline advances as a whole: while the
// output word waits under stall, every stage holds and stall_o is raised.
// The stages are the l*s product, the v/m/span adds, the span-times-fraction
// product and the channel select with byte scaling; the two multipliers set
// the cycle time. Saturation and lightness above one clamp to one.
module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [FRAC_BITS-1:0]               hue_i,
  input  logic [FRAC_BITS:0]                 saturation_i,
  input  logic [FRAC_BITS:0]                 lightness_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic [hsl_pkg::ARGB_W-1:0]         argb_o
);

  localparam int unsigned DEPTH = 4;

  logic                 en;
  logic [DEPTH-1:0]     vld_q, vld_d;
  logic [FRAC_BITS:0]   v, m, d;
  logic [FRAC_BITS-1:0] frac;
  hsl_pkg::sextant_e    sext;

  assign en      = !(vld_q[DEPTH-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[DEPTH-1];
  assign vld_d   = {vld_q[DEPTH-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  hsl_vm #(
    .FRAC_BITS(FRAC_BITS)
  ) u_vm (
    .clk_i       (clk_i),
    .en_i        (en),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .v_o         (v),
    .m_o         (m),
    .d_o         (d),
    .frac_o      (frac),
    .sext_o      (sext)
  );

  hsl_chan #(
    .FRAC_BITS(FRAC_BITS)
  ) u_chan (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (v),
    .m_i   (m),
    .d_i   (d),
    .frac_i(frac),
    .sext_i(sext),
    .argb_o(argb_o)
  );

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved under stall");

  a_m_le_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (m <= v) && (d == v - m))
    else $error("smallest channel exceeds largest channel");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> argb_o[31:24] == hsl_pkg::ALPHA)
    else $error("alpha byte wrong on output word");
`endif

endmodule
